@@ design/mtrd_pkg.sv @@
// Package for the MT19937 ranged draw unit.
// Holds request/response types, sequencer states, generator constants and tempering.
// No dependencies.
package mtrd_pkg;

  // Generator geometry.
  localparam int unsigned MT_WORDS_N = 624;
  localparam int unsigned IDX_W      = $clog2(MT_WORDS_N);

  localparam logic [IDX_W-1:0] MT_WORDS     = IDX_W'(MT_WORDS_N);
  localparam logic [IDX_W-1:0] MT_LAST      = IDX_W'(MT_WORDS_N - 1);
  localparam logic [IDX_W-1:0] MT_SHIFT     = IDX_W'(397);
  localparam logic [IDX_W-1:0] MT_WRAP_OFFS = IDX_W'(MT_WORDS_N - 397);

  // Recurrence and tempering constants.
  localparam logic [31:0] MT_MATRIX       = 32'h9908_b0df;
  localparam logic [31:0] MT_UPPER        = 32'h8000_0000;
  localparam logic [31:0] MT_LOWER        = 32'h7fff_ffff;
  localparam logic [31:0] MT_INIT_MUL     = 32'd1812433253;
  localparam logic [31:0] MT_DEFAULT_SEED = 32'd5489;
  localparam logic [31:0] TEMPER_B        = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C        = 32'hefc6_0000;

  // Request kinds.
  localparam logic KIND_DRAW = 1'b0;
  localparam logic KIND_SEED = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] seed_value;
    logic [30:0] range_max;
  } mtrd_req_t;

  typedef struct packed {
    logic [31:0] tempered_word;
    logic [30:0] scaled_draw;
  } mtrd_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED0,
    ST_SEED_MUL,
    ST_SEED_WR,
    ST_TW_RD0,
    ST_TW_LD0,
    ST_TW_A,
    ST_TW_B,
    ST_TW_C,
    ST_DR_RD,
    ST_DR_TEMPER,
    ST_DR_MUL,
    ST_DR_OUT
  } mtrd_state_e;

  // Standard MT19937 output tempering.
  function automatic logic [31:0] mtrd_temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

@@ design/mersenne_twister_ranged_draw_unit.sv @@
// Top level of the MT19937 ranged draw unit: sequencer, state RAM and shared multiplier.
// Depends on mtrd_pkg, mtrd_ram and mtrd_mul.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------
//   request  | start / busy         | req_i : kind, seed_value, range_max
//   result   | valid_o (one cycle)  | rsp_o : tempered_word, scaled_draw
//
// A draw from a live batch runs ST_DR_RD, ST_DR_TEMPER, ST_DR_MUL and ST_DR_OUT,
// the last carrying the result strobe. A draw that empties the batch first
// regenerates all 624 words, one at a time through ST_TW_A, ST_TW_B and ST_TW_C
// and the single RAM read port. A seed request writes word 0, then each further
// word through ST_SEED_MUL and ST_SEED_WR on the shared multiplier; a draw before
// any seed adds that fill ahead of the regeneration. Reset clears the sequencer,
// the read position and the seeded flag; the RAM needs no clearing. The receiver
// cannot stall; busy stays high until the request ends and holds off any new one.
module mersenne_twister_ranged_draw_unit
  import mtrd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  mtrd_req_t req_i,
  output logic      valid_o,
  output mtrd_rsp_t rsp_o
);

  mtrd_state_e state_q, state_d;

  logic [IDX_W-1:0] rpos_q, rpos_d;
  logic             seeded_q, seeded_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  logic        kind_q;
  logic [31:0] seed_q;
  logic [30:0] range_q;
  logic [31:0] prev_q, prev_d;
  logic [31:0] cur_q, cur_d;
  logic [31:0] nxt_q, nxt_d;
  logic [31:0] word_q, word_d;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [31:0]      ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [31:0]      ram_rdata;

  logic        mul_en;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_prod;

  logic [31:0]      seed_src;
  logic [31:0]      seed_word;
  logic [31:0]      twist_mix;
  logic [31:0]      twist_word;
  logic [IDX_W-1:0] idx_plus1;
  logic [IDX_W-1:0] idx_far;

  mtrd_ram #(
    .WIDTH (32),
    .DEPTH (MT_WORDS_N)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mtrd_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_prod)
  );

  // Neighbor addresses for the in-place twist.
  assign idx_plus1 = (idx_q == MT_LAST) ? '0 : idx_q + IDX_W'(1);
  assign idx_far   = (idx_q < MT_WRAP_OFFS) ? idx_q + MT_SHIFT : idx_q - MT_WRAP_OFFS;

  // Seed recurrence and twist datapath.
  assign seed_src   = (kind_q == KIND_SEED) ? seed_q : MT_DEFAULT_SEED;
  assign seed_word  = mul_prod[31:0] + {{(32-IDX_W){1'b0}}, idx_q};
  assign twist_mix  = (cur_q & MT_UPPER) | (nxt_q & MT_LOWER);
  assign twist_word = ram_rdata ^ (twist_mix >> 1) ^ (nxt_q[0] ? MT_MATRIX : 32'h0);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (req_i.kind == KIND_SEED) begin
            state_d = ST_SEED0;
          end else if (rpos_q != '0) begin
            state_d = ST_DR_RD;
          end else if (seeded_q) begin
            state_d = ST_TW_RD0;
          end else begin
            state_d = ST_SEED0;
          end
        end
      end
      ST_SEED0:     state_d = ST_SEED_MUL;
      ST_SEED_MUL:  state_d = ST_SEED_WR;
      ST_SEED_WR: begin
        if (idx_q == MT_LAST) begin
          state_d = (kind_q == KIND_SEED) ? ST_IDLE : ST_TW_RD0;
        end else begin
          state_d = ST_SEED_MUL;
        end
      end
      ST_TW_RD0:    state_d = ST_TW_LD0;
      ST_TW_LD0:    state_d = ST_TW_A;
      ST_TW_A:      state_d = ST_TW_B;
      ST_TW_B:      state_d = ST_TW_C;
      ST_TW_C:      state_d = (idx_q == MT_LAST) ? ST_DR_RD : ST_TW_A;
      ST_DR_RD:     state_d = ST_DR_TEMPER;
      ST_DR_TEMPER: state_d = ST_DR_MUL;
      ST_DR_MUL:    state_d = ST_DR_OUT;
      ST_DR_OUT:    state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Datapath controls and register updates per state.
  always_comb begin
    rpos_d    = rpos_q;
    seeded_d  = seeded_q;
    idx_d     = idx_q;
    prev_d    = prev_q;
    cur_d     = cur_q;
    nxt_d     = nxt_q;
    word_d    = word_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = seed_word;
    ram_raddr = idx_q;
    mul_en    = 1'b0;
    mul_a     = MT_INIT_MUL;
    mul_b     = prev_q ^ (prev_q >> 30);
    valid_o   = 1'b0;
    unique case (state_q)
      ST_SEED0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = seed_src;
        prev_d    = seed_src;
        idx_d     = IDX_W'(1);
      end
      ST_SEED_MUL: begin
        mul_en = 1'b1;
      end
      ST_SEED_WR: begin
        ram_we = 1'b1;
        prev_d = seed_word;
        if (idx_q == MT_LAST) begin
          seeded_d = 1'b1;
          rpos_d   = '0;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_TW_RD0: begin
        ram_raddr = '0;
        idx_d     = '0;
      end
      ST_TW_LD0: begin
        cur_d = ram_rdata;
      end
      ST_TW_A: begin
        ram_raddr = idx_plus1;
      end
      ST_TW_B: begin
        nxt_d     = ram_rdata;
        ram_raddr = idx_far;
      end
      ST_TW_C: begin
        ram_we    = 1'b1;
        ram_wdata = twist_word;
        cur_d     = nxt_q;
        if (idx_q == MT_LAST) begin
          rpos_d = MT_WORDS;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_DR_RD: begin
        ram_raddr = MT_WORDS - rpos_q;
        rpos_d    = rpos_q - IDX_W'(1);
      end
      ST_DR_TEMPER: begin
        word_d = mtrd_temper(ram_rdata);
      end
      ST_DR_MUL: begin
        mul_en = 1'b1;
        mul_a  = word_q;
        mul_b  = {1'b0, range_q};
      end
      ST_DR_OUT: begin
        valid_o = 1'b1;
      end
      default: begin
        valid_o = 1'b0;
      end
    endcase
  end

  assign busy                = (state_q != ST_IDLE);
  assign rsp_o.tempered_word = word_q;
  assign rsp_o.scaled_draw   = mul_prod[62:32];

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rpos_q   <= '0;
      seeded_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rpos_q   <= rpos_d;
      seeded_q <= seeded_d;
    end
  end

  // Request capture and working registers.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      kind_q  <= req_i.kind;
      seed_q  <= req_i.seed_value;
      range_q <= req_i.range_max;
    end
    idx_q  <= idx_d;
    prev_q <= prev_d;
    cur_q  <= cur_d;
    nxt_q  <= nxt_d;
    word_q <= word_d;
  end

endmodule

@@ design/mtrd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mtrd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ design/mtrd_mul.sv @@
// Shared 32x32 multiplier with a registered 64-bit product.
// Used for the seed recurrence and for range scaling. Depends on nothing.
module mtrd_mul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_q;

  // One product per enabled cycle; held otherwise.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= 64'(a_i) * 64'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

@@ bench/mersenne_twister_ranged_draw_unit_tb.sv @@
// Self-checking bench for the MT19937 ranged draw unit: directed and random
// draw and reseed requests, checked against a predictor held in a scoreboard class.
// Depends on mtrd_pkg and the mersenne_twister_ranged_draw_unit RTL.
module mersenne_twister_ranged_draw_unit_tb;
  import mtrd_pkg::*;

  // Predictor of the generator plus the store of expected draws.
  class twister_scoreboard;
    logic [31:0] words [MT_WORDS_N];
    int unsigned words_left;
    bit          seeded;
    mtrd_rsp_t   pending_draws [$];
    int unsigned errors;
    int unsigned n_draws;
    int unsigned n_seeds;
    int unsigned n_twists;
    int unsigned n_zero_range;

    function new();
      words_left   = 0;
      seeded       = 1'b0;
      errors       = 0;
      n_draws      = 0;
      n_seeds      = 0;
      n_twists     = 0;
      n_zero_range = 0;
    endfunction

    // Standard init recurrence over the whole state.
    function void seed_words(logic [31:0] seed);
      logic [31:0] prev;
      words[0] = seed;
      for (int j = 1; j < MT_WORDS_N; j++) begin
        prev     = words[j-1];
        words[j] = 32'(MT_INIT_MUL * (prev ^ (prev >> 30)) + 32'(j));
      end
      words_left = 0;
      seeded     = 1'b1;
    endfunction

    // Regenerates all words in place, in the standard order.
    function void twist_words();
      logic [31:0] nxt;
      logic [31:0] mix;
      logic [31:0] v;
      if (!seeded) seed_words(MT_DEFAULT_SEED);
      for (int i = 0; i < MT_WORDS_N; i++) begin
        nxt = words[(i + 1) % MT_WORDS_N];
        mix = (words[i] & MT_UPPER) | (nxt & MT_LOWER);
        v   = words[(i + int'(MT_SHIFT)) % MT_WORDS_N] ^ (mix >> 1);
        if (nxt[0]) v = v ^ MT_MATRIX;
        words[i] = v;
      end
      words_left = MT_WORDS_N;
      n_twists++;
    endfunction

    function logic [31:0] temper_word(logic [31:0] w);
      logic [31:0] y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      return y ^ (y >> 18);
    endfunction

    // An accepted request: reseed, or predict the next draw.
    function void note_request(mtrd_req_t r);
      mtrd_rsp_t   exp_rsp;
      logic [63:0] product;
      if (r.kind == KIND_SEED) begin
        seed_words(r.seed_value);
        n_seeds++;
      end else begin
        if (words_left == 0) twist_words();
        exp_rsp.tempered_word = temper_word(words[MT_WORDS_N - words_left]);
        words_left--;
        product = {32'd0, exp_rsp.tempered_word} * {33'd0, r.range_max};
        exp_rsp.scaled_draw = product[62:32];
        pending_draws = {pending_draws, exp_rsp};
        n_draws++;
        if (r.range_max == '0) n_zero_range++;
      end
    endfunction

    // One line per mismatch; every one is counted.
    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(mtrd_rsp_t got);
      mtrd_rsp_t exp_rsp;
      if (pending_draws.size() == 0) begin
        report_mismatch($sformatf("unexpected result word=%h scaled=%h",
                                  got.tempered_word, got.scaled_draw));
      end else begin
        exp_rsp = pending_draws.pop_front();
        if (got.tempered_word !== exp_rsp.tempered_word)
          report_mismatch($sformatf("tempered_word got %h expected %h",
                                    got.tempered_word, exp_rsp.tempered_word));
        if (got.scaled_draw !== exp_rsp.scaled_draw)
          report_mismatch($sformatf("scaled_draw got %h expected %h",
                                    got.scaled_draw, exp_rsp.scaled_draw));
      end
    endtask

    function int unsigned pending();
      return pending_draws.size();
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  mtrd_req_t req_i;
  logic      valid_o;
  mtrd_rsp_t rsp_o;

  twister_scoreboard sb = new();
  int unsigned       n_requests;

  mersenne_twister_ranged_draw_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Every strobed result is checked at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_result(rsp_o);
  end

  // Drive one request from the falling edge and hold it until accepted.
  task automatic send_request(logic kind, logic [31:0] seed, logic [30:0] range_max);
    mtrd_req_t r;
    r.kind       = kind;
    r.seed_value = seed;
    r.range_max  = range_max;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(r);
    n_requests++;
  endtask

  // Lowers start and holds it low for a gap whose length is given by n.
  task automatic idle_for(int unsigned n);
    if (n > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Mostly no gap, often a short one, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [30:0] pick_range();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 31'h7fff_ffff;
      2: return 31'($urandom_range(1, 16));
      3: return 31'(1) << $urandom_range(0, 30);
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return MT_DEFAULT_SEED;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned run_len;
    bit          no_gaps;
    rst_ni     = 1'b0;
    start      = 1'b0;
    req_i      = '0;
    n_requests = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: draws before any seed use the default seed, range extremes,
    // seed extremes, back-to-back reseeds and an explicit default seed.
    send_request(KIND_DRAW, 32'hffff_ffff, 31'h0000_0000);
    send_request(KIND_DRAW, 32'h0000_0000, 31'h7fff_ffff);
    send_request(KIND_DRAW, $urandom,      31'h0000_0001);
    send_request(KIND_DRAW, $urandom,      31'h4000_0000);
    send_request(KIND_SEED, 32'h0000_0000, 31'h7fff_ffff);
    send_request(KIND_DRAW, $urandom,      31'h7fff_ffff);
    send_request(KIND_DRAW, $urandom,      31'h0000_0000);
    send_request(KIND_SEED, 32'hffff_ffff, 31'h0000_0000);
    send_request(KIND_SEED, 32'h1234_5678, 31'($urandom));
    send_request(KIND_DRAW, $urandom,      31'h0000_0000);
    send_request(KIND_DRAW, $urandom,      31'h7fff_ffff);
    send_request(KIND_SEED, MT_DEFAULT_SEED, 31'($urandom));
    send_request(KIND_DRAW, $urandom,      31'h2aaa_aaaa);
    send_request(KIND_DRAW, $urandom,      31'h5555_5555);
    send_request(KIND_DRAW, 32'h8000_0000, 31'h7fff_fffe);
    idle_for(1);
    wait_drained();

    // Random: runs of draws, most short, some long enough to cross a batch
    // boundary, each usually led by a reseed; some reseeds have no draws after them.
    while (n_requests < 1800) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        send_request(KIND_SEED, pick_seed(), pick_range());
        if (!no_gaps) idle_for(pick_gap());
      end
      case ($urandom_range(0, 7))
        0: run_len = 0;
        1: run_len = $urandom_range(650, 900);
        default: run_len = $urandom_range(1, 40);
      endcase
      for (int k = 0; k < run_len && n_requests < 1800; k++) begin
        send_request(KIND_DRAW, $urandom, pick_range());
        if (!no_gaps) idle_for(pick_gap());
      end
      // Now and then hold off until every expected draw has arrived.
      if ($urandom_range(0, 7) == 0) begin
        idle_for(1);
        wait_drained();
      end
    end

    idle_for(1);
    while (sb.pending() != 0 || busy) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Run covered %0d draws (%0d with a zero range) and %0d reseeds,",
             sb.n_draws, sb.n_zero_range, sb.n_seeds);
    $display("which took %0d full-state regenerations; %0d mismatches.",
             sb.n_twists, sb.errors);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest expected run.
  initial begin
    #80000000;
    $display("Timeout with %0d draws still expected.", sb.pending());
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ filelist.f @@
design/mtrd_pkg.sv
design/mtrd_ram.sv
design/mtrd_mul.sv
design/mersenne_twister_ranged_draw_unit.sv
bench/mersenne_twister_ranged_draw_unit_tb.sv
